### rtl/core/multiclass_fast_nms_defines.svh
// Assertion macros used by multiclass_fast_nms.sv.
`ifndef MULTICLASS_FAST_NMS_DEFINES_SVH
`define MULTICLASS_FAST_NMS_DEFINES_SVH
`ifndef SYNTHESIS
`define MNMS_CHECK(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("check failed");
`define MNMS_IMPLY(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication failed");
`else
`define MNMS_CHECK(name, clk, rst_n, expr)
`define MNMS_IMPLY(name, clk, rst_n, pre, post)
`endif
`endif

### rtl/core/mnms_pkg.sv
package mnms_pkg;

    localparam int COORD_W = 16;
    localparam int BOX_W   = 4 * COORD_W;
    localparam int SCORE_W = 16;
    localparam int CLS_W   = 8;
    localparam int ENTRY_W = SCORE_W + CLS_W;
    localparam int FILL_W  = 3;
    localparam int COL_W   = 9;
    localparam int CNT_W   = 7;
    localparam int LIM_W   = 17;
    localparam int CFG_W   = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [COL_W-1:0] COL_SAT = 9'd511;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASSES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DET_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IOU_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_FLR  = 3'd4;

    typedef struct packed {
        logic done;
        logic suppress;
    } iou_res_t;

endpackage

### rtl/core/mnms_ifs.sv
interface mnms_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  corner_y0;
    logic signed [15:0]  corner_x0;
    logic signed [15:0]  corner_y1;
    logic signed [15:0]  corner_x1;
    logic [15:0]         class_score;
    logic                class_last;
    logic                anchor_last;
    modport source (output valid, corner_y0, corner_x0, corner_y1, corner_x1,
                    class_score, class_last, anchor_last, input ready);
    modport sink (input valid, corner_y0, corner_x0, corner_y1, corner_x1,
                  class_score, class_last, anchor_last, output ready);
endinterface

interface mnms_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  det_ymin;
    logic signed [15:0]  det_xmin;
    logic signed [15:0]  det_ymax;
    logic signed [15:0]  det_xmax;
    logic [7:0]          det_class;
    logic [15:0]         det_score;
    logic [6:0]          detection_count;
    logic                is_detection;
    logic                last_result;
    modport source (output valid, det_ymin, det_xmin, det_ymax, det_xmax, det_class,
                    det_score, detection_count, is_detection, last_result, input ready);
    modport sink (input valid, det_ymin, det_xmin, det_ymax, det_xmax, det_class,
                  det_score, detection_count, is_detection, last_result, output ready);
endinterface

### rtl/core/mnms_ram.sv
module mnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/mnms_topk.sv
module mnms_topk #(
    parameter int MAX_K = 4
) (
    input  logic [MAX_K*mnms_pkg::ENTRY_W+mnms_pkg::FILL_W-1:0] row_cur,
    input  logic                                             restart,
    input  logic                                             ins,
    input  logic [mnms_pkg::CLS_W-1:0]                       cls,
    input  logic [mnms_pkg::SCORE_W-1:0]                     score,
    output logic [MAX_K*mnms_pkg::ENTRY_W+mnms_pkg::FILL_W-1:0] row_new
);
    import mnms_pkg::*;

    localparam int FILL_LSB = MAX_K * ENTRY_W;

    logic [FILL_W-1:0] n;
    logic [FILL_W-1:0] pos;
    logic [FILL_W-1:0] lastv;

    always_comb
    begin
        n = restart ? '0 : row_cur[FILL_LSB +: FILL_W];
        pos = '0;
        for (int i = 0; i < MAX_K; i++)
        begin
            if (FILL_W'(i) < n && row_cur[i*ENTRY_W +: SCORE_W] >= score)
            begin
                pos = pos + 1'b1;
            end
        end
        lastv = (n < FILL_W'(MAX_K)) ? n : FILL_W'(MAX_K - 1);
        row_new = row_cur;
        row_new[FILL_LSB +: FILL_W] = n;
        if (ins && pos < FILL_W'(MAX_K))
        begin
            for (int i = 1; i < MAX_K; i++)
            begin
                if (FILL_W'(i) > pos && FILL_W'(i) <= lastv)
                begin
                    row_new[i*ENTRY_W +: ENTRY_W] = row_cur[(i-1)*ENTRY_W +: ENTRY_W];
                end
            end
            for (int i = 0; i < MAX_K; i++)
            begin
                if (FILL_W'(i) == pos)
                begin
                    row_new[i*ENTRY_W +: ENTRY_W] = {cls, score};
                end
            end
            if (n < FILL_W'(MAX_K))
            begin
                row_new[FILL_LSB +: FILL_W] = n + 1'b1;
            end
        end
    end
endmodule

### rtl/core/mnms_iou.sv
module mnms_iou (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mnms_pkg::BOX_W-1:0]   box_a,
    input  logic [mnms_pkg::BOX_W-1:0]   box_b,
    input  logic [mnms_pkg::LIM_W-1:0]   limit,
    output mnms_pkg::iou_res_t           res
);
    import mnms_pkg::*;

    logic signed [15:0] ay0, ax0, ay1, ax1, by0, bx0, by1, bx1;
    logic signed [15:0] aylo, ayhi, axlo, axhi, bylo, byhi, bxlo, bxhi;
    logic signed [16:0] dya, dxa, dyb, dxb, iy, ix;

    logic [15:0] dya_reg, dxa_reg, dyb_reg, dxb_reg, iy_reg, ix_reg;
    logic [31:0] area_a_reg, area_b_reg, inter_reg, inter3_reg, inter4_reg;
    logic [33:0] uni_reg;
    logic        zero3_reg, zero4_reg;
    logic [33:0] plo_reg, phi_reg;
    logic [3:0]  v_reg;
    logic [50:0] rhs;
    logic [50:0] lhs;
    iou_res_t    res_reg;

    always_comb
    begin
        ay0 = box_a[15:0];  ax0 = box_a[31:16]; ay1 = box_a[47:32]; ax1 = box_a[63:48];
        by0 = box_b[15:0];  bx0 = box_b[31:16]; by1 = box_b[47:32]; bx1 = box_b[63:48];
        aylo = (ay0 < ay1) ? ay0 : ay1;
        ayhi = (ay0 < ay1) ? ay1 : ay0;
        axlo = (ax0 < ax1) ? ax0 : ax1;
        axhi = (ax0 < ax1) ? ax1 : ax0;
        bylo = (by0 < by1) ? by0 : by1;
        byhi = (by0 < by1) ? by1 : by0;
        bxlo = (bx0 < bx1) ? bx0 : bx1;
        bxhi = (bx0 < bx1) ? bx1 : bx0;
        dya = 17'(ayhi) - 17'(aylo);
        dxa = 17'(axhi) - 17'(axlo);
        dyb = 17'(byhi) - 17'(bylo);
        dxb = 17'(bxhi) - 17'(bxlo);
        iy = 17'((ayhi < byhi) ? ayhi : byhi) - 17'((aylo > bylo) ? aylo : bylo);
        ix = 17'((axhi < bxhi) ? axhi : bxhi) - 17'((axlo > bxlo) ? axlo : bxlo);
        rhs = {17'd0, plo_reg} + {phi_reg, 17'd0};
        lhs = {3'd0, inter4_reg, 16'd0};
    end

    always_ff @(posedge clk)
    begin
        dya_reg <= dya[15:0];
        dxa_reg <= dxa[15:0];
        dyb_reg <= dyb[15:0];
        dxb_reg <= dxb[15:0];
        iy_reg  <= iy[16] ? 16'd0 : iy[15:0];
        ix_reg  <= ix[16] ? 16'd0 : ix[15:0];
        area_a_reg <= dya_reg * dxa_reg;
        area_b_reg <= dyb_reg * dxb_reg;
        inter_reg  <= iy_reg * ix_reg;
        zero3_reg  <= (area_a_reg == 32'd0) || (area_b_reg == 32'd0);
        uni_reg    <= {2'd0, area_a_reg} + {2'd0, area_b_reg} - {2'd0, inter_reg};
        inter3_reg <= inter_reg;
        zero4_reg  <= zero3_reg;
        inter4_reg <= inter3_reg;
        plo_reg    <= limit * uni_reg[16:0];
        phi_reg    <= limit * uni_reg[33:17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            res_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], start};
            res_reg.done <= v_reg[3];
            res_reg.suppress <= !zero4_reg && (lhs > rhs);
        end
    end

    assign res = res_reg;
endmodule

### rtl/core/multiclass_fast_nms.sv
// Multi-class greedy NMS. During loading the block takes one score column word per
// cycle; the box of each of the first ANCHOR_SLOTS anchors goes to a box memory and
// its sorted top-K class list to a row memory when its last column arrives. The word
// with anchor_last starts suppression. Each suppression round sweeps the row memory
// once, one anchor per cycle, then tests the picked box against the kept boxes in
// turn in the IoU pipeline, stopping at the first one that suppresses it. Every
// candidate taken, whether it is kept or suppressed, costs one round, and one more
// round ends the search. Output then reads each kept anchor's row and sends one
// detection word per kept class; new words are accepted again after the last result.
module multiclass_fast_nms #(
    parameter int ANCHOR_SLOTS = 1024,
    parameter int MAX_CLASSES  = 256,
    parameter int MAX_K        = 4,
    parameter int MAX_DET      = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mnms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mnms_pkg::CFG_W-1:0]       cfg_data,
    mnms_in_if.sink                          anchors,
    mnms_out_if.source                       detections
);
    import mnms_pkg::*;

    `include "multiclass_fast_nms_defines.svh"

    localparam int AW    = (ANCHOR_SLOTS > 1) ? $clog2(ANCHOR_SLOTS) : 1;
    localparam int ACW   = $clog2(ANCHOR_SLOTS + 1);
    localparam int DW    = $clog2(MAX_DET + 1);
    localparam int JW    = (MAX_DET > 1) ? $clog2(MAX_DET) : 1;
    localparam int KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int ROW_W = MAX_K * ENTRY_W + FILL_W;
    localparam int FILL_LSB = MAX_K * ENTRY_W;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_ROUND = 11'b00000000010,
        S_SCAN  = 11'b00000000100,
        S_PWAIT = 11'b00000001000,
        S_ITEST = 11'b00000010000,
        S_IWAIT = 11'b00000100000,
        S_KEEP  = 11'b00001000000,
        S_OREAD = 11'b00010000000,
        S_OWAIT = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_SPARE = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [2:0]       bg_reg;
    logic [2:0]       cpd_reg;
    logic [4:0]       dl_reg;
    logic [LIM_W-1:0] iou_reg;
    logic [SCORE_W-1:0] floor_reg;

    logic [COL_W-1:0] col_reg;
    logic [ACW-1:0]   anc_reg;
    logic [ROW_W-1:0] cur_row_reg;

    logic [ACW-1:0]   scan_reg;
    logic             rd_pend_reg;
    logic [AW-1:0]    idx_d_reg;
    logic             found_reg;
    logic [AW-1:0]    best_idx_reg;
    logic [SCORE_W-1:0] best_sc_reg;
    logic [FILL_W-1:0] best_fill_reg;
    logic             have_last_reg;
    logic [SCORE_W-1:0] last_sc_reg;
    logic [AW-1:0]    last_idx_reg;
    logic [BOX_W-1:0] pb_reg;

    logic [DW-1:0]    kept_cnt_reg;
    logic [JW-1:0]    kj_reg;
    logic [AW-1:0]    kept_idx [MAX_DET];
    logic [BOX_W-1:0] kept_box [MAX_DET];
    logic [FILL_W-1:0] kept_fill [MAX_DET];
    logic [CNT_W-1:0] total_reg;
    logic [ROW_W-1:0] orow_reg;
    logic [KW-1:0]    ocol_reg;
    logic [CNT_W-1:0] emit_reg;
    logic             empty_reg;

    logic             acc;
    logic             inrange;
    logic             anc_end;
    logic [COL_W-1:0] cidx;
    logic             ins;
    logic [ROW_W-1:0] row_new;
    logic [BOX_W-1:0] in_box;
    logic             row_we;
    logic [AW-1:0]    row_raddr;
    logic [ROW_W-1:0] row_rdata;
    logic [BOX_W-1:0] box_rdata;
    logic [SCORE_W-1:0] rd_sc;
    logic [FILL_W-1:0] rd_fill;
    logic             elig;
    logic [FILL_W-1:0] kreq;
    logic [DW-1:0]    limit;
    logic [FILL_W-1:0] kk_best;
    logic [FILL_W-1:0] kk_cur;
    logic             out_fire;
    logic             out_last;
    logic             iou_start;
    iou_res_t         iou_res;
    logic [BOX_W-1:0] obox;

    assign acc     = anchors.valid && anchors.ready;
    assign inrange = anc_reg < ACW'(ANCHOR_SLOTS);
    assign anc_end = anchors.class_last || anchors.anchor_last;
    assign cidx    = col_reg - COL_W'(bg_reg);
    assign ins     = (col_reg >= COL_W'(bg_reg)) && (cidx < COL_W'(MAX_CLASSES)) && inrange;
    assign in_box  = {anchors.corner_x1, anchors.corner_y1, anchors.corner_x0,
                      anchors.corner_y0};
    assign row_we  = acc && anc_end && inrange;
    assign row_raddr = (state_reg == S_SCAN) ? scan_reg[AW-1:0] : kept_idx[kj_reg];

    assign rd_sc   = row_rdata[SCORE_W-1:0];
    assign rd_fill = row_rdata[FILL_LSB +: FILL_W];
    assign elig    = (rd_fill != '0) && (rd_sc > floor_reg) &&
                     (!have_last_reg || rd_sc < last_sc_reg ||
                      (rd_sc == last_sc_reg && idx_d_reg > last_idx_reg));

    assign kreq    = (cpd_reg == 3'd0) ? 3'd1 :
                     ((cpd_reg > FILL_W'(MAX_K)) ? FILL_W'(MAX_K) : cpd_reg);
    assign limit   = (dl_reg > 5'(MAX_DET)) ? DW'(MAX_DET) : DW'(dl_reg);
    assign kk_best = (best_fill_reg < kreq) ? best_fill_reg : kreq;
    assign kk_cur  = (kept_fill[kj_reg] < kreq) ? kept_fill[kj_reg] : kreq;

    assign iou_start = (state_reg == S_ITEST);
    assign out_fire  = detections.valid && detections.ready;
    assign out_last  = empty_reg || (emit_reg + 1'b1 == total_reg);
    assign obox      = kept_box[kj_reg];

    assign anchors.ready               = (state_reg == S_LOAD);
    assign detections.valid            = (state_reg == S_EMIT);
    assign detections.det_ymin         = empty_reg ? '0 : obox[15:0];
    assign detections.det_xmin         = empty_reg ? '0 : obox[31:16];
    assign detections.det_ymax         = empty_reg ? '0 : obox[47:32];
    assign detections.det_xmax         = empty_reg ? '0 : obox[63:48];
    assign detections.det_class        = empty_reg ? '0 :
                                         orow_reg[ocol_reg*ENTRY_W+SCORE_W +: CLS_W];
    assign detections.det_score        = empty_reg ? '0 : orow_reg[ocol_reg*ENTRY_W +: SCORE_W];
    assign detections.detection_count  = empty_reg ? '0 : total_reg;
    assign detections.is_detection     = !empty_reg;
    assign detections.last_result      = out_last;

    mnms_topk #(.MAX_K(MAX_K)) u_topk (
        .row_cur (cur_row_reg),
        .restart (col_reg == '0),
        .ins     (ins),
        .cls     (cidx[CLS_W-1:0]),
        .score   (anchors.class_score),
        .row_new (row_new)
    );

    mnms_ram #(.WIDTH(ROW_W), .DEPTH(ANCHOR_SLOTS)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (anc_reg[AW-1:0]),
        .wdata (row_new),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    mnms_ram #(.WIDTH(BOX_W), .DEPTH(ANCHOR_SLOTS)) u_box_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (anc_reg[AW-1:0]),
        .wdata (in_box),
        .raddr (best_idx_reg),
        .rdata (box_rdata)
    );

    mnms_iou u_iou (
        .clk   (clk),
        .rst_n (rst_n),
        .start (iou_start),
        .box_a (pb_reg),
        .box_b (kept_box[kj_reg]),
        .limit (iou_reg),
        .res   (iou_res)
    );

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cur_row_reg <= row_new;
        end
        if (state_reg == S_SCAN && rd_pend_reg && elig && (!found_reg || rd_sc > best_sc_reg))
        begin
            best_idx_reg  <= idx_d_reg;
            best_sc_reg   <= rd_sc;
            best_fill_reg <= rd_fill;
        end
        if (state_reg == S_SCAN)
        begin
            idx_d_reg <= scan_reg[AW-1:0];
        end
        if (state_reg == S_PWAIT)
        begin
            pb_reg <= box_rdata;
        end
        if (state_reg == S_KEEP)
        begin
            kept_idx[kept_cnt_reg[JW-1:0]]  <= best_idx_reg;
            kept_box[kept_cnt_reg[JW-1:0]]  <= pb_reg;
            kept_fill[kept_cnt_reg[JW-1:0]] <= best_fill_reg;
        end
        if (state_reg == S_OWAIT)
        begin
            orow_reg <= row_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            bg_reg        <= 3'd0;
            cpd_reg       <= 3'd1;
            dl_reg        <= 5'd16;
            iou_reg       <= 17'd32768;
            floor_reg     <= '0;
            col_reg       <= '0;
            anc_reg       <= '0;
            scan_reg      <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            have_last_reg <= 1'b0;
            last_sc_reg   <= '0;
            last_idx_reg  <= '0;
            kept_cnt_reg  <= '0;
            kj_reg        <= '0;
            total_reg     <= '0;
            ocol_reg      <= '0;
            emit_reg      <= '0;
            empty_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BACKGROUND: bg_reg    <= cfg_data[2:0];
                    CFG_CLASSES:    cpd_reg   <= cfg_data[2:0];
                    CFG_DET_LIMIT:  dl_reg    <= cfg_data[4:0];
                    CFG_IOU_LIMIT:  iou_reg   <= cfg_data[LIM_W-1:0];
                    CFG_SCORE_FLR:  floor_reg <= cfg_data[SCORE_W-1:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (acc)
                    begin
                        if (anc_end)
                        begin
                            col_reg <= '0;
                            if (inrange)
                            begin
                                anc_reg <= anc_reg + 1'b1;
                            end
                        end
                        else if (col_reg < COL_SAT)
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                        if (anchors.anchor_last)
                        begin
                            kept_cnt_reg  <= '0;
                            have_last_reg <= 1'b0;
                            total_reg     <= '0;
                            state_reg     <= S_ROUND;
                        end
                    end
                end
                S_ROUND:
                begin
                    if (kept_cnt_reg >= limit)
                    begin
                        kj_reg    <= '0;
                        emit_reg  <= '0;
                        empty_reg <= (total_reg == '0);
                        state_reg <= S_OREAD;
                    end
                    else
                    begin
                        scan_reg    <= '0;
                        found_reg   <= 1'b0;
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg < anc_reg)
                    begin
                        scan_reg    <= scan_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                    end
                    if (rd_pend_reg && elig)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (scan_reg == anc_reg && !rd_pend_reg)
                    begin
                        if (found_reg)
                        begin
                            have_last_reg <= 1'b1;
                            last_sc_reg   <= best_sc_reg;
                            last_idx_reg  <= best_idx_reg;
                            state_reg     <= S_PWAIT;
                        end
                        else
                        begin
                            kj_reg    <= '0;
                            emit_reg  <= '0;
                            empty_reg <= (total_reg == '0);
                            state_reg <= S_OREAD;
                        end
                    end
                end
                S_PWAIT:
                begin
                    kj_reg    <= '0;
                    state_reg <= (kept_cnt_reg == '0) ? S_KEEP : S_ITEST;
                end
                S_ITEST:
                begin
                    state_reg <= S_IWAIT;
                end
                S_IWAIT:
                begin
                    if (iou_res.done)
                    begin
                        if (iou_res.suppress)
                        begin
                            state_reg <= S_ROUND;
                        end
                        else if (DW'(kj_reg) + 1'b1 == kept_cnt_reg)
                        begin
                            state_reg <= S_KEEP;
                        end
                        else
                        begin
                            kj_reg    <= kj_reg + 1'b1;
                            state_reg <= S_ITEST;
                        end
                    end
                end
                S_KEEP:
                begin
                    kept_cnt_reg <= kept_cnt_reg + 1'b1;
                    total_reg    <= total_reg + CNT_W'(kk_best);
                    state_reg    <= S_ROUND;
                end
                S_OREAD:
                begin
                    state_reg <= empty_reg ? S_EMIT : S_OWAIT;
                end
                S_OWAIT:
                begin
                    ocol_reg  <= '0;
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (out_fire)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (out_last)
                        begin
                            anc_reg   <= '0;
                            col_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else if (FILL_W'(ocol_reg) + 1'b1 == kk_cur)
                        begin
                            kj_reg    <= kj_reg + 1'b1;
                            state_reg <= S_OREAD;
                        end
                        else
                        begin
                            ocol_reg <= ocol_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    `MNMS_IMPLY(a_phase_excl, clk, rst_n, detections.valid, !anchors.ready)
    `MNMS_CHECK(a_kept_bound, clk, rst_n, kept_cnt_reg <= DW'(MAX_DET))
    `MNMS_IMPLY(a_emit_bound, clk, rst_n, detections.valid && !empty_reg,
                emit_reg < total_reg)
endmodule
